[sv/byte_stream_tokenizer_core_defines.svh]
// assertion macros for the tokenizer, empty when SYNTH is defined
`ifndef BYTE_STREAM_TOKENIZER_CORE_DEFINES_SVH
`define BYTE_STREAM_TOKENIZER_CORE_DEFINES_SVH

`ifndef SYNTH

`define BST_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("tokenizer assertion failed");

`define BST_ASSERT_NEVER(name, clk, rst_n, expr) \
	`BST_ASSERT(name, clk, rst_n, !(expr))

`else

`define BST_ASSERT(name, clk, rst_n, prop)
`define BST_ASSERT_NEVER(name, clk, rst_n, expr)

`endif

`endif

[sv/bst_pkg.sv]
`default_nettype none

package bst_pkg;

	// byte classes found by the front end
	typedef enum logic [3:0] {
		CH_ZERO,
		CH_DIGIT,
		CH_ALPHA,
		CH_SPACE,
		CH_NEWLINE,
		CH_OP,
		CH_CMP,
		CH_BRACE,
		CH_CMD,
		CH_BAD
	} ch_class_t;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_NUMBER,
		MODE_NAME,
		MODE_COMPARE,
		MODE_HALT
	} scan_mode_t;

	typedef enum logic [2:0] {
		TC_NUMBER,
		TC_OPERATOR,
		TC_COMPARE,
		TC_BRACE,
		TC_COMMAND,
		TC_NAME,
		TC_END,
		TC_ERROR
	} tok_class_t;

	// comparison characters
	localparam logic [1:0] CK_LT   = 2'd0;
	localparam logic [1:0] CK_GT   = 2'd1;
	localparam logic [1:0] CK_EQ   = 2'd2;
	localparam logic [1:0] CK_BANG = 2'd3;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;

	localparam logic [2:0] BR_LPAREN = 3'd0;
	localparam logic [2:0] BR_RPAREN = 3'd1;
	localparam logic [2:0] BR_LCURLY = 3'd2;
	localparam logic [2:0] BR_RCURLY = 3'd3;

	localparam logic [2:0] CMP_NOT = 3'd0;
	localparam logic [2:0] CMP_EQ  = 3'd1;
	localparam logic [2:0] CMP_NE  = 3'd2;
	localparam logic [2:0] CMP_GT  = 3'd3;
	localparam logic [2:0] CMP_LT  = 3'd4;
	localparam logic [2:0] CMP_LE  = 3'd5;
	localparam logic [2:0] CMP_GE  = 3'd6;

	localparam logic [2:0] CMD_PRINT  = 3'd0;
	localparam logic [2:0] CMD_QUERY  = 3'd1;
	localparam logic [2:0] CMD_ASSIGN = 3'd2;
	localparam logic [2:0] CMD_SEMI   = 3'd3;
	localparam logic [2:0] CMD_IF     = 3'd4;
	localparam logic [2:0] CMD_WHILE  = 3'd5;

	localparam logic [2:0] ERR_SYMBOL = 3'd0;
	localparam logic [2:0] ERR_PAIR   = 3'd1;

	localparam logic [30:0] NUM_MAX  = '1;
	localparam logic [15:0] LINE_MAX = '1;
	localparam int          NAME_BYTES = 8;

	// keywords packed with the first character in the low byte
	localparam logic [63:0] KW_PRINT = 64'h0000_0074_6E69_7270;
	localparam logic [63:0] KW_IF    = 64'h0000_0000_0000_6669;
	localparam logic [63:0] KW_WHILE = 64'h0000_0065_6C69_6877;

	localparam int IQ_DEPTH = 4;
	localparam int OQ_DEPTH = 4;

	typedef struct packed {
		ch_class_t   cls;
		logic [2:0]  sub;
		logic [7:0]  ch;
	} cls_item_t;

	typedef struct packed {
		tok_class_t  cls;
		logic [2:0]  detail;
		logic [15:0] line;
		logic [30:0] num;
		logic [63:0] chars;
		logic [3:0]  len;
		logic        last;
	} token_t;

	typedef struct packed {
		logic [1:0] cnt;
		token_t     tok0;
		token_t     tok1;
	} tok_wr_t;

endpackage

`default_nettype wire

[sv/bst_front.sv]
`default_nettype none

module bst_front
	import bst_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	output logic           full,
	input  wire logic [7:0] source_byte,
	output logic           hd_vld,
	output cls_item_t      hd_item,
	input  wire logic      hd_take
);

	localparam int PW = $clog2(IQ_DEPTH);
	localparam int CW = $clog2(IQ_DEPTH + 1);

	cls_item_t         mem_q [IQ_DEPTH];
	logic [PW-1:0]     wp_q;
	logic [PW-1:0]     rp_q;
	logic [CW-1:0]     cnt_q;
	logic              acc;
	cls_item_t         cls_in;

	// sort the byte into its class and per-class code
	always_comb begin
		cls_in.ch  = source_byte;
		cls_in.sub = 3'd0;
		cls_in.cls = CH_BAD;
		if (source_byte == 8'd0) begin
			cls_in.cls = CH_ZERO;
		end else if (source_byte >= "0" && source_byte <= "9") begin
			cls_in.cls = CH_DIGIT;
		end else if ((source_byte >= "a" && source_byte <= "z") ||
				(source_byte >= "A" && source_byte <= "Z")) begin
			cls_in.cls = CH_ALPHA;
		end else if (source_byte == 8'd10) begin
			cls_in.cls = CH_NEWLINE;
		end else if (source_byte == " " || (source_byte >= 8'd9 && source_byte <= 8'd13)) begin
			cls_in.cls = CH_SPACE;
		end else begin
			case (source_byte)
				"+": begin cls_in.cls = CH_OP;    cls_in.sub = OP_ADD; end
				"-": begin cls_in.cls = CH_OP;    cls_in.sub = OP_SUB; end
				"*": begin cls_in.cls = CH_OP;    cls_in.sub = OP_MUL; end
				"/": begin cls_in.cls = CH_OP;    cls_in.sub = OP_DIV; end
				"<": begin cls_in.cls = CH_CMP;   cls_in.sub = {1'b0, CK_LT}; end
				">": begin cls_in.cls = CH_CMP;   cls_in.sub = {1'b0, CK_GT}; end
				"=": begin cls_in.cls = CH_CMP;   cls_in.sub = {1'b0, CK_EQ}; end
				"!": begin cls_in.cls = CH_CMP;   cls_in.sub = {1'b0, CK_BANG}; end
				"(": begin cls_in.cls = CH_BRACE; cls_in.sub = BR_LPAREN; end
				")": begin cls_in.cls = CH_BRACE; cls_in.sub = BR_RPAREN; end
				"{": begin cls_in.cls = CH_BRACE; cls_in.sub = BR_LCURLY; end
				"}": begin cls_in.cls = CH_BRACE; cls_in.sub = BR_RCURLY; end
				"?": begin cls_in.cls = CH_CMD;   cls_in.sub = CMD_QUERY; end
				";": begin cls_in.cls = CH_CMD;   cls_in.sub = CMD_SEMI; end
				default: begin cls_in.cls = CH_BAD; end
			endcase
		end
	end

	assign full    = (cnt_q == CW'(IQ_DEPTH));
	assign acc     = push && !full;
	assign hd_vld  = (cnt_q != '0);
	assign hd_item = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (acc) begin
			mem_q[wp_q] <= cls_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (acc) begin
				wp_q <= PW'((int'(wp_q) + 1) % IQ_DEPTH);
			end
			if (hd_take) begin
				rp_q <= PW'((int'(rp_q) + 1) % IQ_DEPTH);
			end
			cnt_q <= cnt_q + CW'(acc) - CW'(hd_take);
		end
	end

endmodule

`default_nettype wire

[sv/bst_scan.sv]
`default_nettype none

`include "byte_stream_tokenizer_core_defines.svh"

module bst_scan
	import bst_pkg::*;
#(
	parameter int MAX_NAME = 8
)
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      hd_vld,
	input  cls_item_t      hd_item,
	output logic           hd_take,
	input  wire logic      room,
	output tok_wr_t        wr
);

	scan_mode_t   mode_q, mode_d;
	logic [30:0]  acc_q, acc_d;
	logic         sat_q, sat_d;
	logic [63:0]  buf_q, buf_d;
	logic [3:0]   cnt_q, cnt_d;
	logic [1:0]   pend_q, pend_d;
	logic [15:0]  line_q, line_d;

	logic         halted, num_cont, name_cont, cmp_pair;
	logic         is_zero, is_digit, is_alpha;
	logic [34:0]  num_next;
	logic [1:0]   ck;
	token_t       blank, flush_tok, fresh_tok;
	logic         do_flush, flush_vld, fresh_vld;

	assign hd_take   = hd_vld && room;
	assign is_zero   = (hd_item.cls == CH_ZERO);
	assign is_digit  = (hd_item.cls == CH_DIGIT);
	assign is_alpha  = (hd_item.cls == CH_ALPHA);
	assign ck        = hd_item.sub[1:0];
	assign halted    = (mode_q == MODE_HALT);
	assign num_cont  = (mode_q == MODE_NUMBER) && is_digit;
	assign name_cont = (mode_q == MODE_NAME) && (is_digit || is_alpha);
	assign cmp_pair  = (mode_q == MODE_COMPARE) && (hd_item.cls == CH_CMP);
	// acc*10 + digit as two shifted adds
	assign num_next  = 35'({acc_q, 3'b000}) + 35'({acc_q, 1'b0}) + 35'(hd_item.ch[3:0]);

	// next state
	always_comb begin
		mode_d = mode_q;
		acc_d  = acc_q;
		sat_d  = sat_q;
		buf_d  = buf_q;
		cnt_d  = cnt_q;
		pend_d = pend_q;
		line_d = line_q;
		if (hd_take) begin
			if (halted || is_zero) begin
				if (is_zero) begin
					mode_d = MODE_IDLE;
					acc_d  = '0;
					sat_d  = 1'b0;
					buf_d  = '0;
					cnt_d  = '0;
					pend_d = '0;
					line_d = 16'd1;
				end
			end else if (num_cont) begin
				if (num_next > 35'(NUM_MAX)) begin
					acc_d = NUM_MAX;
					sat_d = 1'b1;
				end else begin
					acc_d = num_next[30:0];
				end
			end else if (name_cont) begin
				if (cnt_q < 4'(MAX_NAME)) begin
					for (int i = 0; i < NAME_BYTES; i++) begin
						if (cnt_q[2:0] == 3'(i)) begin
							buf_d[8*i +: 8] = hd_item.ch;
						end
					end
					cnt_d = cnt_q + 4'd1;
				end else begin
					sat_d = 1'b1;
				end
			end else begin
				mode_d = MODE_IDLE;
				acc_d  = '0;
				sat_d  = 1'b0;
				buf_d  = '0;
				cnt_d  = '0;
				pend_d = '0;
				if (cmp_pair) begin
					if (ck != CK_EQ) begin
						mode_d = MODE_HALT;
					end
				end else begin
					case (hd_item.cls)
						CH_NEWLINE: begin
							if (line_q != LINE_MAX) begin
								line_d = line_q + 16'd1;
							end
						end
						CH_DIGIT: begin
							mode_d = MODE_NUMBER;
							acc_d  = 31'(hd_item.ch[3:0]);
						end
						CH_CMP: begin
							mode_d = MODE_COMPARE;
							pend_d = ck;
						end
						CH_ALPHA: begin
							mode_d = MODE_NAME;
							buf_d  = 64'(hd_item.ch);
							cnt_d  = 4'd1;
						end
						CH_BAD: begin
							mode_d = MODE_HALT;
						end
						default: begin
						end
					endcase
				end
			end
		end
	end

	// token outputs
	always_comb begin
		blank.cls    = TC_NUMBER;
		blank.detail = 3'd0;
		blank.line   = line_q;
		blank.num    = '0;
		blank.chars  = '0;
		blank.len    = '0;
		blank.last   = 1'b0;
		flush_tok    = blank;
		fresh_tok    = blank;
		do_flush     = 1'b0;
		fresh_vld    = 1'b0;
		flush_vld    = 1'b0;
		if (hd_take) begin
			if (halted) begin
				if (is_zero) begin
					fresh_vld     = 1'b1;
					fresh_tok.cls = TC_END;
				end
			end else if (is_zero) begin
				do_flush      = 1'b1;
				fresh_vld     = 1'b1;
				fresh_tok.cls = TC_END;
			end else if (num_cont || name_cont) begin
				fresh_vld = 1'b0;
			end else if (cmp_pair) begin
				fresh_vld = 1'b1;
				if (ck == CK_EQ) begin
					fresh_tok.cls = TC_COMPARE;
					case (pend_q)
						CK_LT:   fresh_tok.detail = CMP_LE;
						CK_GT:   fresh_tok.detail = CMP_GE;
						CK_EQ:   fresh_tok.detail = CMP_EQ;
						default: fresh_tok.detail = CMP_NE;
					endcase
				end else begin
					fresh_tok.cls    = TC_ERROR;
					fresh_tok.detail = ERR_PAIR;
				end
			end else begin
				do_flush = 1'b1;
				case (hd_item.cls)
					CH_OP: begin
						fresh_vld     = 1'b1;
						fresh_tok.cls = TC_OPERATOR;
						fresh_tok.detail = hd_item.sub;
					end
					CH_BRACE: begin
						fresh_vld     = 1'b1;
						fresh_tok.cls = TC_BRACE;
						fresh_tok.detail = hd_item.sub;
					end
					CH_CMD: begin
						fresh_vld     = 1'b1;
						fresh_tok.cls = TC_COMMAND;
						fresh_tok.detail = hd_item.sub;
					end
					CH_BAD: begin
						fresh_vld     = 1'b1;
						fresh_tok.cls = TC_ERROR;
						fresh_tok.detail = ERR_SYMBOL;
					end
					default: begin
						fresh_vld = 1'b0;
					end
				endcase
			end
		end
		if (do_flush) begin
			case (mode_q)
				MODE_NUMBER: begin
					flush_vld        = 1'b1;
					flush_tok.cls    = TC_NUMBER;
					flush_tok.detail = {2'b00, sat_q};
					flush_tok.num    = acc_q;
				end
				MODE_NAME: begin
					flush_vld = 1'b1;
					if (!sat_q && cnt_q == 4'd5 && buf_q == KW_PRINT) begin
						flush_tok.cls    = TC_COMMAND;
						flush_tok.detail = CMD_PRINT;
					end else if (!sat_q && cnt_q == 4'd2 && buf_q == KW_IF) begin
						flush_tok.cls    = TC_COMMAND;
						flush_tok.detail = CMD_IF;
					end else if (!sat_q && cnt_q == 4'd5 && buf_q == KW_WHILE) begin
						flush_tok.cls    = TC_COMMAND;
						flush_tok.detail = CMD_WHILE;
					end else begin
						flush_tok.cls    = TC_NAME;
						flush_tok.detail = {2'b00, sat_q};
						flush_tok.chars  = buf_q;
						flush_tok.len    = cnt_q;
					end
				end
				MODE_COMPARE: begin
					flush_vld = 1'b1;
					case (pend_q)
						CK_LT: begin
							flush_tok.cls = TC_COMPARE;
							flush_tok.detail = CMP_LT;
						end
						CK_GT: begin
							flush_tok.cls = TC_COMPARE;
							flush_tok.detail = CMP_GT;
						end
						CK_EQ: begin
							flush_tok.cls = TC_COMMAND;
							flush_tok.detail = CMD_ASSIGN;
						end
						default: begin
							flush_tok.cls = TC_COMPARE;
							flush_tok.detail = CMP_NOT;
						end
					endcase
				end
				default: begin
					flush_vld = 1'b0;
				end
			endcase
		end
		// pack so the first valid token sits in slot 0, last flag on the final one
		wr.cnt  = 2'(flush_vld) + 2'(fresh_vld);
		wr.tok0 = flush_vld ? flush_tok : fresh_tok;
		wr.tok1 = fresh_tok;
		wr.tok0.last = !(flush_vld && fresh_vld);
		wr.tok1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			acc_q  <= '0;
			sat_q  <= 1'b0;
			buf_q  <= '0;
			cnt_q  <= '0;
			pend_q <= '0;
			line_q <= 16'd1;
		end else begin
			mode_q <= mode_d;
			acc_q  <= acc_d;
			sat_q  <= sat_d;
			buf_q  <= buf_d;
			cnt_q  <= cnt_d;
			pend_q <= pend_d;
			line_q <= line_d;
		end
	end

	`BST_ASSERT(a_halt_silent, clk, arst_n, (hd_take && halted && !is_zero) |-> (wr.cnt == 2'd0))
	`BST_ASSERT(a_end_restarts, clk, arst_n, (hd_take && is_zero) |=> (line_q == 16'd1 && mode_q == MODE_IDLE))
	`BST_ASSERT_NEVER(a_pair_without_room, clk, arst_n, (wr.cnt != 2'd0) && !room)

endmodule

`default_nettype wire

[sv/bst_outq.sv]
`default_nettype none

`include "byte_stream_tokenizer_core_defines.svh"

module bst_outq
	import bst_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  tok_wr_t        wr,
	output logic           room,
	output logic           empty,
	input  wire logic      pop,
	output token_t         head
);

	localparam int PW = $clog2(OQ_DEPTH);
	localparam int CW = $clog2(OQ_DEPTH + 1);

	token_t          mem_q [OQ_DEPTH];
	logic [PW-1:0]   wp_q;
	logic [PW-1:0]   rp_q;
	logic [CW-1:0]   cnt_q;
	logic [PW-1:0]   wp_nx;
	logic            rd;

	assign wp_nx = PW'((int'(wp_q) + 1) % OQ_DEPTH);
	assign empty = (cnt_q == '0);
	assign rd    = pop && !empty;
	assign head  = mem_q[rp_q];
	// two free entries so a byte that yields two tokens never blocks halfway
	assign room  = (cnt_q <= CW'(OQ_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (wr.cnt != 2'd0) begin
			mem_q[wp_q] <= wr.tok0;
		end
		if (wr.cnt == 2'd2) begin
			mem_q[wp_nx] <= wr.tok1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= PW'((int'(wp_q) + int'(wr.cnt)) % OQ_DEPTH);
			if (rd) begin
				rp_q <= PW'((int'(rp_q) + 1) % OQ_DEPTH);
			end
			cnt_q <= cnt_q + CW'(wr.cnt) - CW'(rd);
		end
	end

	`BST_ASSERT(a_no_overflow, clk, arst_n, (wr.cnt != 2'd0) |-> (int'(cnt_q) + int'(wr.cnt) <= OQ_DEPTH))
	`BST_ASSERT(a_drains_empty, clk, arst_n, (rd && cnt_q == CW'(1) && wr.cnt == 2'd0) |=> empty)
	`BST_ASSERT(a_pair_lands, clk, arst_n, (wr.cnt == 2'd2) |=> (cnt_q >= CW'(2)))

endmodule

`default_nettype wire

[sv/byte_stream_tokenizer_core.sv]
// byte stream tokenizer
// input side is a queue: drive source_byte and push, a request is taken when full is low.
// result side is a queue: while empty is low the oldest token is on token_class,
// token_detail, line_number, number_value, name_chars, name_length and last_of_run;
// pop takes it. each byte gives zero, one or two tokens, last_of_run marks the final one.
// a token reaches the result ports once the byte completing it has passed the byte queue
// and the scanner has written the token into the result queue; the scanner can stall between.
// throughput is one byte per cycle; the scanner stalls only when the result queue
// has fewer than two free entries, so a byte that yields two tokens costs the reader
// two pops. when the reader stops popping, the 4-entry result queue fills to under two free
// entries, then the 4-entry byte queue fills and full rises; nothing is dropped.
// byte 0 flushes any pending token, emits an end token and resets the line to 1.
// after reset the scanner is idle at line 1 and both queues are empty; the block
// takes bytes as soon as reset is released, since full is then low.
`default_nettype none

module byte_stream_tokenizer_core
	import bst_pkg::*;
#(
	parameter int MAX_NAME = 8
)
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  source_byte,
	output logic             empty,
	input  wire logic        pop,
	output logic [2:0]       token_class,
	output logic [2:0]       token_detail,
	output logic [15:0]      line_number,
	output logic [30:0]      number_value,
	output logic [63:0]      name_chars,
	output logic [3:0]       name_length,
	output logic             last_of_run
);

	logic       hd_vld;
	cls_item_t  hd_item;
	logic       hd_take;
	logic       room;
	tok_wr_t    wr;
	token_t     head;

	bst_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.source_byte (source_byte),
		.hd_vld      (hd_vld),
		.hd_item     (hd_item),
		.hd_take     (hd_take)
	);

	bst_scan #(
		.MAX_NAME (MAX_NAME)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.hd_vld  (hd_vld),
		.hd_item (hd_item),
		.hd_take (hd_take),
		.room    (room),
		.wr      (wr)
	);

	bst_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.room   (room),
		.empty  (empty),
		.pop    (pop),
		.head   (head)
	);

	assign token_class  = head.cls;
	assign token_detail = head.detail;
	assign line_number  = head.line;
	assign number_value = head.num;
	assign name_chars   = head.chars;
	assign name_length  = head.len;
	assign last_of_run  = head.last;

endmodule

`default_nettype wire
